/* hw/rtl/sal_pkg.sv */
// Shared constants and types for the set-associative lookup block.
package sal_pkg;

    localparam int unsigned DEF_NUM_SETS  = 64;
    localparam int unsigned DEF_WAYS      = 4;
    localparam int unsigned DEF_KEY_WIDTH = 32;

    // Fixed widths of the channel words
    localparam int unsigned IN_KEY_W   = 32;
    localparam int unsigned HASH_W     = 32;
    localparam int unsigned PICK_W     = 2;
    localparam int unsigned SET_OUT_W  = 6;
    localparam int unsigned WAY_OUT_W  = 2;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // Memory strobes from the controller to the tag store
    typedef struct packed {
        logic rd_en;
        logic vld_we;
        logic key_we;
    } t_mem_ctl;

endpackage

/* hw/rtl/sal_if.sv */
// Request and response channel interfaces.
interface sal_req_if import sal_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [IN_KEY_W-1:0] key;
    logic [HASH_W-1:0]   hash;
    logic [PICK_W-1:0]   victim_pick;

    modport source (output valid, operation, key, hash, victim_pick, input ready);
    modport sink   (input valid, operation, key, hash, victim_pick, output ready);
endinterface

interface sal_rsp_if import sal_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [SET_OUT_W-1:0] set_index;
    logic [WAY_OUT_W-1:0] way;
    logic                 evicted;
    logic [IN_KEY_W-1:0]  evicted_key;

    modport source (output valid, hit, set_index, way, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, set_index, way, evicted, evicted_key, output ready);
endinterface

/* hw/rtl/sal_store.sv */
// Tag store: valid-bit memory and key memory, one row per set, registered reads.
module sal_store import sal_pkg::*; #(
    parameter  int unsigned NUM_SETS  = DEF_NUM_SETS,
    parameter  int unsigned WAYS      = DEF_WAYS,
    parameter  int unsigned KEY_WIDTH = DEF_KEY_WIDTH,
    localparam int unsigned SW        = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
    localparam int unsigned WW        = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic                            i_clk,
    input  t_mem_ctl                        i_ctl,
    input  logic [SW-1:0]                   i_rd_set,
    input  logic [SW-1:0]                   i_wr_set,
    input  logic [WAYS-1:0]                 i_vld_row,
    input  logic [WW-1:0]                   i_key_way,
    input  logic [KEY_WIDTH-1:0]            i_key,
    output logic [WAYS-1:0]                 o_vld,
    output logic [WAYS-1:0][KEY_WIDTH-1:0]  o_keys
);

    logic [WAYS-1:0]                r_vld_mem [NUM_SETS];
    logic [WAYS-1:0][KEY_WIDTH-1:0] r_key_mem [NUM_SETS];
    logic [WAYS-1:0]                r_vld_q;
    logic [WAYS-1:0][KEY_WIDTH-1:0] r_keys_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld_we) begin
            r_vld_mem[i_wr_set] <= i_vld_row;
        end
        if (i_ctl.key_we) begin
            r_key_mem[i_wr_set][i_key_way] <= i_key;
        end
        if (i_ctl.rd_en) begin
            r_vld_q  <= r_vld_mem[i_rd_set];
            r_keys_q <= r_key_mem[i_rd_set];
        end
    end

    assign o_vld  = r_vld_q;
    assign o_keys = r_keys_q;

endmodule

/* hw/rtl/sal_scan.sv */
// Way scan: hit search, free-way pick and random victim selection for one set.
module sal_scan import sal_pkg::*; #(
    parameter  int unsigned WAYS      = DEF_WAYS,
    parameter  int unsigned KEY_WIDTH = DEF_KEY_WIDTH,
    localparam int unsigned WW        = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic [WAYS-1:0]                 i_vld,
    input  logic [WAYS-1:0][KEY_WIDTH-1:0]  i_keys,
    input  logic [KEY_WIDTH-1:0]            i_key,
    input  logic [PICK_W-1:0]               i_pick,
    output logic                            o_hit,
    output logic                            o_free,
    output logic [WW-1:0]                   o_slot,
    output logic [KEY_WIDTH-1:0]            o_ev_key
);

    // victim width holds WAYS itself for the reduction compare
    localparam int unsigned VW         = (WW + 1 > PICK_W) ? WW + 1 : PICK_W;
    localparam int unsigned PICK_STEPS = (1 << PICK_W) - 1;

    logic [WAYS-1:0] hit_vec;
    logic [WW-1:0]   hit_slot;
    logic [WW-1:0]   free_slot;
    logic [VW-1:0]   vic;
    logic [WW-1:0]   vic_slot;

    always_comb begin
        hit_vec   = '0;
        hit_slot  = '0;
        free_slot = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = i_vld[w] && (i_keys[w] == i_key);
        end
        // first matching way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_slot = WW'(w);
            end
        end
        // last invalid way wins
        for (int w = 0; w < WAYS; w++) begin
            if (!i_vld[w]) begin
                free_slot = WW'(w);
            end
        end
        // victim = pick mod WAYS
        vic = VW'(i_pick);
        for (int s = 0; s < PICK_STEPS; s++) begin
            if (vic >= VW'(WAYS)) begin
                vic = vic - VW'(WAYS);
            end
        end
        vic_slot = WW'(vic);
    end

    assign o_hit    = |hit_vec;
    assign o_free   = ~&i_vld;
    assign o_slot   = o_hit ? hit_slot : (o_free ? free_slot : vic_slot);
    assign o_ev_key = i_keys[vic_slot];

endmodule

/* hw/rtl/set_assoc_lookup_random_replace.sv */
// Set-associative key lookup with random replacement: controller and top level.
//
// Usage
//   i_req carries one word per operation: operation (0 lookup-or-allocate,
//   1 clear all), key, hash and victim_pick. o_rsp returns exactly one word
//   per request: hit, set_index, way, evicted and evicted_key.
//   Set = hash mod NUM_SETS; the keys of a set sit in one memory row.
// Sequence
//   Power-of-two NUM_SETS: a lookup is accepted, the set row is read in the
//   same cycle, and in the next cycle the ways are compared; when the response
//   register is free, the claimed way is written back and the register loaded.
//   Other NUM_SETS: S_MOD forms the quotient by reciprocal multiply and S_READ
//   forms the remainder and reads the set row. A clear sweeps the valid memory
//   one set per cycle. One request in flight; ready high when idle.
// Reset
//   After reset the valid memory is swept clear with i_req.ready low.
//   Key memory contents are never cleared.
// Backpressure
//   The response register holds a finished word while o_rsp.ready is low;
//   the next request is still taken and waits at write-back until it drains.
module set_assoc_lookup_random_replace import sal_pkg::*; #(
    parameter int unsigned NUM_SETS  = DEF_NUM_SETS,
    parameter int unsigned WAYS      = DEF_WAYS,
    parameter int unsigned KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sal_req_if.sink   i_req,
    sal_rsp_if.source o_rsp
);

    localparam int unsigned SW       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned WW       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit          IS_POW2  = (NUM_SETS & (NUM_SETS - 1)) == 0;
    localparam logic [SW-1:0] SET_MASK = SW'(NUM_SETS - 1);
    localparam logic [SW-1:0] SET_LAST = SW'(NUM_SETS - 1);

    // hash / NUM_SETS = (hash * RECIP) >> RECIP_SH, exact for any 32-bit hash
    localparam int unsigned RECIP_SH = HASH_W + $clog2(NUM_SETS);
    localparam int unsigned RECIP_W  = HASH_W + 1;
    localparam int unsigned PROD_W   = HASH_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));
    localparam logic [SW-1:0] SET_NUM_LO = SW'(NUM_SETS);

    typedef enum logic [2:0] {
        S_CLEAR,   // valid sweep, one set per cycle
        S_IDLE,    // waiting for a request
        S_MOD,     // reciprocal quotient of the hash
        S_READ,    // remainder, set row read
        S_LOOK     // compare, write back, load response
    } t_state;

    t_state                 r_state, n_state;
    logic [SW-1:0]          r_cnt, n_cnt;
    t_op                    r_op, n_op;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [HASH_W-1:0]      r_hash, n_hash;
    logic [PICK_W-1:0]      r_pick, n_pick;
    logic [SW-1:0]          r_set, n_set;
    logic [SW-1:0]          r_quo, n_quo;

    // response register
    logic                   r_out_valid, n_out_valid;
    logic                   r_o_hit, n_o_hit;
    logic [SET_OUT_W-1:0]   r_o_set, n_o_set;
    logic [WAY_OUT_W-1:0]   r_o_way, n_o_way;
    logic                   r_o_evicted, n_o_evicted;
    logic [IN_KEY_W-1:0]    r_o_ev_key, n_o_ev_key;

    // tag store and scan
    t_mem_ctl                       mem_ctl;
    logic [SW-1:0]                  rd_set;
    logic [SW-1:0]                  wr_set;
    logic [WAYS-1:0]                vld_row;
    logic [WAYS-1:0]                rd_vld;
    logic [WAYS-1:0][KEY_WIDTH-1:0] rd_keys;
    logic                           scan_hit;
    logic                           scan_free;
    logic [WW-1:0]                  scan_slot;
    logic [KEY_WIDTH-1:0]           scan_ev_key;

    logic                   slot_free;
    logic [SW-1:0]          hash_set;
    logic [PROD_W-1:0]      recip_prod;
    logic [SW-1:0]          rem_set;

    sal_store #(
        .NUM_SETS  (NUM_SETS),
        .WAYS      (WAYS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_set  (rd_set),
        .i_wr_set  (wr_set),
        .i_vld_row (vld_row),
        .i_key_way (scan_slot),
        .i_key     (r_key),
        .o_vld     (rd_vld),
        .o_keys    (rd_keys)
    );

    sal_scan #(
        .WAYS      (WAYS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_scan (
        .i_vld    (rd_vld),
        .i_keys   (rd_keys),
        .i_key    (r_key),
        .i_pick   (r_pick),
        .o_hit    (scan_hit),
        .o_free   (scan_free),
        .o_slot   (scan_slot),
        .o_ev_key (scan_ev_key)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign hash_set    = SW'(i_req.hash) & SET_MASK;

    // remainder = hash - quotient * NUM_SETS; it is below NUM_SETS, so the
    // low SW bits of each term are enough
    assign recip_prod = PROD_W'(r_hash) * PROD_W'(RECIP);
    assign rem_set    = r_hash[SW-1:0] - r_quo * SET_NUM_LO;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_key       = r_key;
        n_hash      = r_hash;
        n_pick      = r_pick;
        n_set       = r_set;
        n_quo       = r_quo;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_o_hit     = r_o_hit;
        n_o_set     = r_o_set;
        n_o_way     = r_o_way;
        n_o_evicted = r_o_evicted;
        n_o_ev_key  = r_o_ev_key;
        mem_ctl     = '0;
        rd_set      = r_set;
        wr_set      = r_set;
        vld_row     = rd_vld | (WAYS'(1) << scan_slot);

        case (r_state)
            S_CLEAR: begin
                mem_ctl.vld_we = 1'b1;
                wr_set         = r_cnt;
                vld_row        = '0;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == SET_LAST) begin
                    // a clear request still owes its response word
                    n_state = (r_op == OP_CLEAR) ? S_LOOK : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op   = t_op'(i_req.operation);
                    n_key  = KEY_WIDTH'(i_req.key);
                    n_hash = i_req.hash;
                    n_pick = i_req.victim_pick;
                    if (t_op'(i_req.operation) == OP_CLEAR) begin
                        n_cnt   = '0;
                        n_state = S_CLEAR;
                    end else if (IS_POW2) begin
                        mem_ctl.rd_en = 1'b1;
                        rd_set        = hash_set;
                        n_set         = hash_set;
                        n_state       = S_LOOK;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                n_quo   = SW'(recip_prod >> RECIP_SH);
                n_state = S_READ;
            end
            S_READ: begin
                mem_ctl.rd_en = 1'b1;
                rd_set        = rem_set;
                n_set         = rem_set;
                n_state       = S_LOOK;
            end
            S_LOOK: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_op == OP_CLEAR) begin
                        n_o_hit     = 1'b0;
                        n_o_set     = '0;
                        n_o_way     = '0;
                        n_o_evicted = 1'b0;
                        n_o_ev_key  = '0;
                    end else begin
                        n_o_hit     = scan_hit;
                        n_o_set     = SET_OUT_W'(r_set);
                        n_o_way     = WAY_OUT_W'(scan_slot);
                        n_o_evicted = !scan_hit && !scan_free;
                        n_o_ev_key  = (!scan_hit && !scan_free) ? IN_KEY_W'(scan_ev_key)
                                                                : '0;
                        if (!scan_hit) begin
                            mem_ctl.vld_we = 1'b1;
                            mem_ctl.key_we = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_hash     <= n_hash;
        r_pick     <= n_pick;
        r_set      <= n_set;
        r_quo      <= n_quo;
        r_o_hit    <= n_o_hit;
        r_o_set    <= n_o_set;
        r_o_way    <= n_o_way;
        r_o_evicted <= n_o_evicted;
        r_o_ev_key <= n_o_ev_key;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_op        <= OP_LOOKUP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_o_hit;
    assign o_rsp.set_index   = r_o_set;
    assign o_rsp.way         = r_o_way;
    assign o_rsp.evicted     = r_o_evicted;
    assign o_rsp.evicted_key = r_o_ev_key;

endmodule

/* hw/rtl/sal_checker.sv */
// Port-level assertions for the lookup block, bound to the top level.
module sal_checker import sal_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_valid,
    input logic                 i_req_ready,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input logic                 i_rsp_hit,
    input logic [SET_OUT_W-1:0] i_rsp_set_index,
    input logic [WAY_OUT_W-1:0] i_rsp_way,
    input logic                 i_rsp_evicted,
    input logic [IN_KEY_W-1:0]  i_rsp_evicted_key
);

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_hit)
            && $stable(i_rsp_set_index) && $stable(i_rsp_way)
            && $stable(i_rsp_evicted) && $stable(i_rsp_evicted_key))
        else $error("response word changed while stalled");

    // one request in flight: ready drops after each accepted word
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted twice in a row");

    // a hit never evicts, and no eviction means a zero key
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_hit |-> !i_rsp_evicted)
        else $error("hit reported with eviction");

    a_ev_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_evicted |-> i_rsp_evicted_key == '0)
        else $error("evicted key nonzero without eviction");

    // reset starts the clearing sweep: no requests taken, no response
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready && !i_rsp_valid)
        else $error("block active right after reset");

endmodule

bind set_assoc_lookup_random_replace sal_checker u_sal_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_hit         (o_rsp.hit),
    .i_rsp_set_index   (o_rsp.set_index),
    .i_rsp_way         (o_rsp.way),
    .i_rsp_evicted     (o_rsp.evicted),
    .i_rsp_evicted_key (o_rsp.evicted_key)
);
